// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent assertions, clocked on the rising edge and
// switched off while the asynchronous reset is applied.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lca assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lca assertion failed: next-cycle implication");

`endif

// ----- rtl/lcabl_pkg.sv -----
// ----------------------------------------------------------------------------
// lcabl_pkg
// Types and constants shared by the binary-lifting ancestor block.
// ----------------------------------------------------------------------------
package lcabl_pkg;

	// Node numbers and depths have fixed widths at the ports.
	localparam int NODE_W = 12;
	localparam int DEPTH_W = 13;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [DEPTH_W-1:0] depth_t;

	// Depths saturate at the top of their range.
	localparam depth_t DEPTH_MAX = 13'd8191;

	// Item kinds carried by the mode field.
	typedef enum logic {
		MODE_LOAD  = 1'b0,
		MODE_QUERY = 1'b1
	} mode_t;

	// Table access request from the sequencer to the table store.
	typedef struct packed {
		logic   jump_we;
		node_t  jump_wr_node;
		node_t  jump_wr_data;
		node_t  jump_rd_node_a;
		node_t  jump_rd_node_b;
		logic   depth_we;
		node_t  depth_wr_node;
		depth_t depth_wr_data;
		node_t  depth_rd_node_a;
		node_t  depth_rd_node_b;
	} lcabl_req_t;

endpackage

// ----- rtl/lcabl_tables.sv -----
// ----------------------------------------------------------------------------
// lcabl_tables
// Jump table and depth table with one write and two registered reads each.
// Node 0 is the sentinel: every read of its row returns zero.
// ----------------------------------------------------------------------------
module lcabl_tables import lcabl_pkg::*; #(
	parameter int MAX_NODES = 4096,
	parameter int LEVELS = 13,
	localparam int LW = $clog2(LEVELS)
) (
	input  logic          clk,
	input  lcabl_req_t    req,
	input  logic [LW-1:0] rd_level,
	input  logic [LW-1:0] wr_level,
	output node_t         jump_a,
	output node_t         jump_b,
	output depth_t        depth_a,
	output depth_t        depth_b
);

	localparam int JAW = $clog2(MAX_NODES * LEVELS);
	localparam int DAW = $clog2(MAX_NODES);

	node_t  jump_mem [MAX_NODES * LEVELS];
	depth_t depth_mem [MAX_NODES];

	logic [JAW-1:0] jump_wr_addr;
	logic [JAW-1:0] jump_rd_addr_a;
	logic [JAW-1:0] jump_rd_addr_b;

	node_t  jump_a_q;
	node_t  jump_b_q;
	depth_t depth_a_q;
	depth_t depth_b_q;
	logic   jump_a_zero_q;
	logic   jump_b_zero_q;
	logic   depth_a_zero_q;
	logic   depth_b_zero_q;

	// Each node owns a row of LEVELS consecutive jump entries.
	assign jump_wr_addr   = JAW'(req.jump_wr_node) * JAW'(LEVELS) + JAW'(wr_level);
	assign jump_rd_addr_a = JAW'(req.jump_rd_node_a) * JAW'(LEVELS) + JAW'(rd_level);
	assign jump_rd_addr_b = JAW'(req.jump_rd_node_b) * JAW'(LEVELS) + JAW'(rd_level);

	// Jump table: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (req.jump_we) begin
			jump_mem[jump_wr_addr] <= req.jump_wr_data;
		end
		jump_a_q      <= jump_mem[jump_rd_addr_a];
		jump_b_q      <= jump_mem[jump_rd_addr_b];
		jump_a_zero_q <= (req.jump_rd_node_a == '0);
		jump_b_zero_q <= (req.jump_rd_node_b == '0);
	end

	// Depth table: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (req.depth_we) begin
			depth_mem[DAW'(req.depth_wr_node)] <= req.depth_wr_data;
		end
		depth_a_q      <= depth_mem[DAW'(req.depth_rd_node_a)];
		depth_b_q      <= depth_mem[DAW'(req.depth_rd_node_b)];
		depth_a_zero_q <= (req.depth_rd_node_a == '0);
		depth_b_zero_q <= (req.depth_rd_node_b == '0);
	end

	// The sentinel row is never written, so it is forced to zero on read.
	assign jump_a  = jump_a_zero_q  ? '0 : jump_a_q;
	assign jump_b  = jump_b_zero_q  ? '0 : jump_b_q;
	assign depth_a = depth_a_zero_q ? '0 : depth_a_q;
	assign depth_b = depth_b_zero_q ? '0 : depth_b_q;

endmodule

// ----- rtl/lca_binary_lifting.sv -----
// ----------------------------------------------------------------------------
// lca_binary_lifting: lowest common ancestor by binary lifting.
// Load beat: busy, no result; each jump
//   level needs one table read and one write, bound by the registered read.
// Query beat: a depth read, a lifting pass per level on x then y, a meeting
//   pass over the levels and a final step to the parent; done rises as busy falls.
// Reset clears the sequencer and the strobe; the tables keep no reset and
//   the sentinel row reads as zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
module lca_binary_lifting import lcabl_pkg::*; #(
	parameter int MAX_NODES = 4096,
	parameter int LEVELS = 13
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  mode,
	input  node_t node_a,
	input  node_t node_b,
	output logic  busy,
	output logic  done,
	output node_t ancestor
);

	localparam int LW = $clog2(LEVELS);
	localparam int CW = ((DEPTH_W > LEVELS) ? DEPTH_W : LEVELS) + 1;
	localparam logic [LW-1:0] TOP_LEVEL = LW'(LEVELS - 1);

	typedef enum logic [15:0] {
		ST_IDLE       = 16'b0000_0000_0000_0001,
		ST_LD_DEPTH   = 16'b0000_0000_0000_0010,
		ST_LD_LINK    = 16'b0000_0000_0000_0100,
		ST_LD_WR      = 16'b0000_0000_0000_1000,
		ST_LD_RD      = 16'b0000_0000_0001_0000,
		ST_Q_DEPTH    = 16'b0000_0000_0010_0000,
		ST_Q_CHK_X    = 16'b0000_0000_0100_0000,
		ST_Q_JMP_X    = 16'b0000_0000_1000_0000,
		ST_Q_WAIT_X   = 16'b0000_0001_0000_0000,
		ST_Q_CHK_Y    = 16'b0000_0010_0000_0000,
		ST_Q_JMP_Y    = 16'b0000_0100_0000_0000,
		ST_Q_WAIT_Y   = 16'b0000_1000_0000_0000,
		ST_Q_MEET_RD  = 16'b0001_0000_0000_0000,
		ST_Q_MEET_CMP = 16'b0010_0000_0000_0000,
		ST_Q_FINAL    = 16'b0100_0000_0000_0000,
		ST_Q_DONE     = 16'b1000_0000_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;
	logic   done_d;

	// During a load x_q holds the current ancestor link and y_q the new node.
	node_t         x_q;
	node_t         y_q;
	logic [LW-1:0] k_q;
	node_t         ancestor_q;

	lcabl_req_t    req;
	logic [LW-1:0] rd_level;
	logic [LW-1:0] wr_level;
	node_t         jump_a;
	node_t         jump_b;
	depth_t        depth_a;
	depth_t        depth_b;

	depth_t        cmp_lhs;
	depth_t        cmp_rhs;
	logic          cmp_ge;

	logic          load_ok;
	node_t         clip_a;
	node_t         clip_b;
	depth_t        depth_next;

	lcabl_tables #(
		.MAX_NODES (MAX_NODES),
		.LEVELS    (LEVELS)
	) u_tables (
		.clk      (clk),
		.req      (req),
		.rd_level (rd_level),
		.wr_level (wr_level),
		.jump_a   (jump_a),
		.jump_b   (jump_b),
		.depth_a  (depth_a),
		.depth_b  (depth_b)
	);

	// Input screening: loads of node 0 or out-of-range nodes are dropped, out-of-range queries use node 0.
	assign load_ok = (node_a != '0) && (32'(node_a) < 32'(MAX_NODES)) &&
		(32'(node_b) < 32'(MAX_NODES));
	assign clip_a = (32'(node_a) < 32'(MAX_NODES)) ? node_a : '0;
	assign clip_b = (32'(node_b) < 32'(MAX_NODES)) ? node_b : '0;

	// New depth is the parent's depth plus one, saturating.
	assign depth_next = (depth_a == DEPTH_MAX) ? DEPTH_MAX : depth_a + 1'b1;

	// Shared depth compare: lhs minus 2^k reaches rhs. The Y check swaps the operands.
	always_comb begin
		if (state_q == ST_Q_CHK_Y) begin
			cmp_lhs = depth_b;
			cmp_rhs = depth_a;
		end else begin
			cmp_lhs = depth_a;
			cmp_rhs = depth_b;
		end
		cmp_ge = CW'(cmp_lhs) >= (CW'(cmp_rhs) + (CW'(1) << k_q));
	end

	// Table requests. Reads default to the current pair at level k.
	always_comb begin
		req = '0;
		req.jump_rd_node_a  = x_q;
		req.jump_rd_node_b  = y_q;
		req.depth_rd_node_a = x_q;
		req.depth_rd_node_b = y_q;
		req.jump_wr_node    = y_q;
		req.depth_wr_node   = y_q;
		req.depth_wr_data   = depth_next;
		req.jump_wr_data    = jump_a;
		rd_level            = k_q;
		wr_level            = k_q;
		case (state_q)
			ST_LD_DEPTH: begin
				// Level 0 of the new row is the parent itself.
				req.jump_we      = 1'b1;
				req.jump_wr_data = x_q;
				wr_level         = '0;
			end
			ST_LD_LINK: begin
				req.depth_we = 1'b1;
				rd_level     = LW'(k_q - 1'b1);
			end
			ST_LD_RD: begin
				rd_level = LW'(k_q - 1'b1);
			end
			ST_LD_WR: begin
				req.jump_we = 1'b1;
			end
			ST_Q_FINAL: begin
				rd_level = '0;
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (mode == MODE_QUERY) begin
						state_d = ST_Q_DEPTH;
					end else if (load_ok) begin
						state_d = ST_LD_DEPTH;
					end
				end
			end
			ST_LD_DEPTH:  state_d = ST_LD_LINK;
			ST_LD_LINK:   state_d = ST_LD_WR;
			ST_LD_WR: begin
				state_d = (k_q == TOP_LEVEL) ? ST_IDLE : ST_LD_RD;
			end
			ST_LD_RD:     state_d = ST_LD_WR;
			ST_Q_DEPTH:   state_d = ST_Q_CHK_X;
			ST_Q_CHK_X: begin
				state_d = cmp_ge ? ST_Q_JMP_X : ST_Q_CHK_Y;
			end
			ST_Q_JMP_X:   state_d = ST_Q_WAIT_X;
			ST_Q_WAIT_X:  state_d = ST_Q_CHK_Y;
			ST_Q_CHK_Y: begin
				if (cmp_ge) begin
					state_d = ST_Q_JMP_Y;
				end else begin
					state_d = (k_q == '0) ? ST_Q_MEET_RD : ST_Q_CHK_X;
				end
			end
			ST_Q_JMP_Y:   state_d = ST_Q_WAIT_Y;
			ST_Q_WAIT_Y: begin
				state_d = (k_q == '0) ? ST_Q_MEET_RD : ST_Q_CHK_X;
			end
			ST_Q_MEET_RD: state_d = ST_Q_MEET_CMP;
			ST_Q_MEET_CMP: begin
				state_d = (k_q == '0) ? ST_Q_FINAL : ST_Q_MEET_RD;
			end
			ST_Q_FINAL: begin
				if (x_q == y_q) begin
					state_d = ST_IDLE;
					done_d  = 1'b1;
				end else begin
					state_d = ST_Q_DONE;
				end
			end
			ST_Q_DONE: begin
				state_d = ST_IDLE;
				done_d  = 1'b1;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	// Working registers: node pair, level counter and result.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (mode == MODE_QUERY) begin
					x_q <= clip_a;
					y_q <= clip_b;
					k_q <= TOP_LEVEL;
				end else begin
					x_q <= node_b;
					y_q <= node_a;
					k_q <= LW'(1);
				end
			end
			ST_LD_WR: begin
				x_q <= jump_a;
				k_q <= LW'(k_q + 1'b1);
			end
			ST_Q_JMP_X: begin
				x_q <= jump_a;
			end
			ST_Q_JMP_Y: begin
				y_q <= jump_b;
			end
			ST_Q_CHK_Y: begin
				if (!cmp_ge) begin
					k_q <= (k_q == '0) ? TOP_LEVEL : LW'(k_q - 1'b1);
				end
			end
			ST_Q_WAIT_Y: begin
				k_q <= (k_q == '0) ? TOP_LEVEL : LW'(k_q - 1'b1);
			end
			ST_Q_MEET_CMP: begin
				// Jump both while their ancestors at this level still differ.
				if (jump_a != jump_b) begin
					x_q <= jump_a;
					y_q <= jump_b;
				end
				k_q <= LW'(k_q - 1'b1);
			end
			ST_Q_FINAL: begin
				ancestor_q <= x_q;
			end
			ST_Q_DONE: begin
				ancestor_q <= jump_a;
			end
			default: begin
			end
		endcase
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign ancestor = ancestor_q;

endmodule

// ----- rtl/lcabl_checker.sv -----
// ----------------------------------------------------------------------------
// lcabl_checker
// Port-level checks on the command handshake of the ancestor block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcabl_checker import lcabl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic mode,
	input logic busy,
	input logic done
);

	// A result beat comes only when the block has gone back to idle.
	`ASSERT_IMPL(a_done_not_busy, clk, arst_n, done, !busy)

	// A result beat lasts exactly one cycle.
	`ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)

	// A result beat always ends a busy period.
	`ASSERT_IMPL(a_done_after_busy, clk, arst_n, done, $past(busy))

	// An accepted query keeps the block busy on the next cycle.
	`ASSERT_NEXT(a_query_busy, clk, arst_n, start && !busy && mode == MODE_QUERY, busy)

	// A load never produces a result beat.
	`ASSERT_NEXT(a_load_silent, clk, arst_n, start && !busy && mode == MODE_LOAD, !done)

endmodule

bind lca_binary_lifting lcabl_checker u_lcabl_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.mode   (mode),
	.busy   (busy),
	.done   (done)
);
